@@ src/rar4_header_walk_name_extract_macros.svh @@
// Assertion macros shared by the RAR v4 header walker.
`ifndef RAR4_HEADER_WALK_NAME_EXTRACT_MACROS_SVH
`define RAR4_HEADER_WALK_NAME_EXTRACT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define RAR4HW_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define RAR4HW_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rar4hw_pkg.sv @@
// Types and constants for the RAR v4 header walker.
package rar4hw_pkg;

	localparam logic [7:0] KindFile   = 8'h74;
	localparam int         BaseLen    = 7;
	localparam int         FileHdrLen = 25;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_BASE = 3'd1,
		PH_FILE = 3'd2,
		PH_NAME = 3'd3,
		PH_SKIP = 3'd4
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  name_byte;
		logic        first;
		logic        last;
		logic        trunc;
		logic [31:0] packed_len;
	} name_res_t;

	typedef struct packed {
		phase_t phase;
		logic   in_name;
	} walk_stat_t;

endpackage

@@ src/rar4hw_ifs.sv @@
// Stream interfaces for archive words in and name words out.
interface rar4hw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] archive_byte;
	logic       stream_last;

	modport source (output valid, archive_byte, stream_last, input ready);
	modport sink   (input valid, archive_byte, stream_last, output ready);
endinterface

interface rar4hw_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  name_byte;
	logic        name_first;
	logic        name_last;
	logic        name_truncated;
	logic [31:0] packed_length;

	modport source (output valid, name_byte, name_first, name_last, name_truncated,
		packed_length, input ready);
	modport sink   (input valid, name_byte, name_first, name_last, name_truncated,
		packed_length, output ready);
endinterface

@@ src/rar4hw_walker.sv @@
// Block header walk state machine: field capture, skip counting, name results.
module rar4hw_walker
	import rar4hw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output name_res_t  res,
	output walk_stat_t stat
);

	phase_t      phase_q, phase_d;
	logic [5:0]  idx_q, idx_d;
	logic [7:0]  kind_q, kind_d;
	logic [15:0] hsize_q, hsize_d;
	logic [31:0] packed_q, packed_d;
	logic [15:0] nlen_q, nlen_d;
	logic [15:0] nrem_q, nrem_d;
	logic [32:0] skip_q, skip_d;

	logic [5:0]  idx_inc;
	logic [15:0] hs_eff;
	logic [16:0] hdr_used;
	logic [15:0] hdr_rest;
	logic [32:0] fin_count;
	phase_t      fin_phase;
	logic [15:0] hsize_full;
	logic [15:0] base_eff;
	logic [32:0] base_count;
	phase_t      base_phase;
	logic        name_final;

	assign idx_inc = idx_q + 6'd1;

	// Skip after a file header: rest of header (saturated) plus packed data.
	assign hs_eff    = (hsize_q < 16'(BaseLen)) ? 16'(BaseLen) : hsize_q;
	assign hdr_used  = 17'(BaseLen + FileHdrLen) + {1'b0, nlen_q};
	assign hdr_rest  = ({1'b0, hs_eff} >= hdr_used) ? (hs_eff - hdr_used[15:0]) : 16'd0;
	assign fin_count = {1'b0, packed_q} + {17'd0, hdr_rest};
	assign fin_phase = (fin_count == 33'd0) ? PH_BASE : PH_SKIP;

	// Skip after a non-file base header; size high byte arrives this word.
	assign hsize_full = {byte_in, hsize_q[7:0]};
	assign base_eff   = (hsize_full < 16'(BaseLen)) ? 16'(BaseLen) : hsize_full;
	assign base_count = {17'd0, base_eff - 16'(BaseLen)};
	assign base_phase = (base_count == 33'd0) ? PH_BASE : PH_SKIP;

	assign name_final = (nrem_q == 16'd1);

	assign stat.phase   = phase_q;
	assign stat.in_name = (phase_q == PH_NAME);

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		kind_d   = kind_q;
		hsize_d  = hsize_q;
		packed_d = packed_q;
		nlen_d   = nlen_q;
		nrem_d   = nrem_q;
		skip_d   = skip_q;

		res.valid      = 1'b0;
		res.name_byte  = byte_in;
		res.first      = (nrem_q == nlen_q);
		res.last       = name_final || last_in;
		res.trunc      = last_in && !name_final;
		res.packed_len = packed_q;

		unique case (phase_q)
			PH_SIG: begin
				if (idx_q == 6'(BaseLen - 1)) begin
					idx_d   = 6'd0;
					phase_d = PH_BASE;
				end else begin
					idx_d = idx_inc;
				end
			end
			PH_BASE: begin
				idx_d = idx_inc;
				if (idx_q == 6'd2) begin
					kind_d = byte_in;
				end else if (idx_q == 6'd5) begin
					hsize_d = {8'd0, byte_in};
				end else if (idx_q == 6'd6) begin
					hsize_d = hsize_full;
				end
				if (idx_q == 6'(BaseLen - 1)) begin
					idx_d = 6'd0;
					if (kind_q == KindFile) begin
						packed_d = 32'd0;
						nlen_d   = 16'd0;
						nrem_d   = 16'd0;
						phase_d  = PH_FILE;
					end else begin
						skip_d  = base_count;
						phase_d = base_phase;
					end
				end
			end
			PH_FILE: begin
				idx_d = idx_inc;
				if (idx_q < 6'd4) begin
					packed_d[8*idx_q[1:0] +: 8] = byte_in;
				end else if (idx_q == 6'd19) begin
					nlen_d = {8'd0, byte_in};
				end else if (idx_q == 6'd20) begin
					nlen_d = {byte_in, nlen_q[7:0]};
				end
				if (idx_q == 6'(FileHdrLen - 1)) begin
					idx_d  = 6'd0;
					nrem_d = nlen_q;
					if (nlen_q != 16'd0) begin
						phase_d = PH_NAME;
					end else begin
						skip_d  = fin_count;
						phase_d = fin_phase;
					end
				end
			end
			PH_NAME: begin
				res.valid = 1'b1;
				nrem_d    = nrem_q - 16'd1;
				if (name_final) begin
					idx_d   = 6'd0;
					skip_d  = fin_count;
					phase_d = fin_phase;
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 33'd1;
				if (skip_q == 33'd1) begin
					idx_d   = 6'd0;
					phase_d = PH_BASE;
				end
			end
			default: begin
				idx_d   = 6'd0;
				phase_d = PH_SIG;
			end
		endcase

		// End of archive: back to the signature with all fields cleared.
		if (last_in) begin
			phase_d  = PH_SIG;
			idx_d    = 6'd0;
			kind_d   = 8'd0;
			hsize_d  = 16'd0;
			packed_d = 32'd0;
			nlen_d   = 16'd0;
			nrem_d   = 16'd0;
			skip_d   = 33'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			idx_q    <= 6'd0;
			kind_q   <= 8'd0;
			hsize_q  <= 16'd0;
			packed_q <= 32'd0;
			nlen_q   <= 16'd0;
			nrem_q   <= 16'd0;
			skip_q   <= 33'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			kind_q   <= kind_d;
			hsize_q  <= hsize_d;
			packed_q <= packed_d;
			nlen_q   <= nlen_d;
			nrem_q   <= nrem_d;
			skip_q   <= skip_d;
		end
	end

endmodule

@@ src/rar4_header_walk_name_extract.sv @@
// Top level of the RAR v4 header walker: input stage, walker, name output register.

// Takes an old-format RAR archive one word (byte) per cycle on archive and
// streams the file names found in its file blocks on names, one word per name
// byte, each tagged with first/last marks and the packed size of its file.
// The 7-byte signature is skipped, then every block's base header is parsed;
// file blocks also have their 25-byte file header parsed before the name, and
// header remainder plus packed data are counted past. stream_last ends the
// archive and returns the walker to the signature; a name cut short there is
// closed with name_last and name_truncated. Each word is registered, then the
// walker updates its counters and fields in one pass, and a name word lands in
// the output register, from which it is presented on names. Sustained rate is
// one word per cycle, stalled only while a name word waits on a full output
// register.

`include "rar4_header_walk_name_extract_macros.svh"

module rar4_header_walk_name_extract
	import rar4hw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rar4hw_in_if.sink   archive,
	rar4hw_out_if.source names
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       out_free;
	logic       step;
	logic       in_ready;
	name_res_t  walk_res;
	walk_stat_t walk_stat;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_first_q;
	logic        out_last_q;
	logic        out_trunc_q;
	logic [31:0] out_packed_q;

	// Advance the held word unless it is a name word blocked by a full output.
	assign out_free = !out_valid_q || names.ready;
	assign step     = valid_s1 && (!walk_stat.in_name || out_free);
	assign in_ready = !valid_s1 || step;

	assign archive.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= archive.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && archive.valid) begin
			byte_s1 <= archive.archive_byte;
			last_s1 <= archive.stream_last;
		end
	end

	rar4hw_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.res     (walk_res),
		.stat    (walk_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && walk_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (names.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && walk_res.valid) begin
			out_byte_q   <= walk_res.name_byte;
			out_first_q  <= walk_res.first;
			out_last_q   <= walk_res.last;
			out_trunc_q  <= walk_res.trunc;
			out_packed_q <= walk_res.packed_len;
		end
	end

	assign names.valid          = out_valid_q;
	assign names.name_byte      = out_byte_q;
	assign names.name_first     = out_first_q;
	assign names.name_last      = out_last_q;
	assign names.name_truncated = out_trunc_q;
	assign names.packed_length  = out_packed_q;

	`RAR4HW_IMPLY(a_no_overwrite, step && walk_res.valid, !out_valid_q || names.ready,
		"name word loaded over an untaken one")
	`RAR4HW_NEXT(a_stage_hold, valid_s1 && !step, valid_s1 && $stable(byte_s1) && $stable(last_s1),
		"held input word changed while stalled")
	`RAR4HW_NEXT(a_last_resets, step && last_s1, walk_stat.phase == PH_SIG,
		"walker not back at signature after end of archive")
	`RAR4HW_IMPLY(a_trunc_closes, out_valid_q && out_trunc_q, out_last_q,
		"truncated name word without last mark")

endmodule

@@ sim/tb_rar4_header_walk_name_extract.sv @@
// Testbench for the RAR v4 header walker: archive stimulus, name word prediction and checking.
module tb_rar4_header_walk_name_extract;
	import rar4hw_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;
	} archive_item_t;

	typedef struct {
		logic [7:0]  name_byte;
		logic        name_first;
		logic        name_last;
		logic        name_truncated;
		logic [31:0] packed_length;
	} name_word_t;

	logic clk;
	logic arst_n;

	rar4hw_in_if  archive_if();
	rar4hw_out_if names_if();

	rar4_header_walk_name_extract uut (
		.clk    (clk),
		.arst_n (arst_n),
		.archive(archive_if),
		.names  (names_if)
	);

	archive_item_t archive_pending[$];
	logic [7:0]    archive_draft[$];
	name_word_t    name_words_due[$];
	int            fail_count;
	int            planned_names;

	// Walker mirror
	phase_t      walk_phase;
	logic [5:0]  hdr_idx;
	logic [7:0]  blk_kind;
	logic [15:0] blk_hsize;
	logic [31:0] pack_size;
	logic [15:0] name_len;
	logic [15:0] name_left;
	logic [32:0] skip_left;

	function automatic void walk_reset();
		walk_phase = PH_SIG;
		hdr_idx = '0;
		blk_kind = '0;
		blk_hsize = '0;
		pack_size = '0;
		name_len = '0;
		name_left = '0;
		skip_left = '0;
	endfunction

	function automatic int eff_header_size();
		return (int'(blk_hsize) < BaseLen) ? BaseLen : int'(blk_hsize);
	endfunction

	function automatic void begin_skip(logic [32:0] count);
		hdr_idx = '0;
		skip_left = count;
		walk_phase = (count == '0) ? PH_BASE : PH_SKIP;
	endfunction

	function automatic void close_file_header();
		int     used;
		longint rest;
		used = BaseLen + FileHdrLen + int'(name_len);
		rest = (eff_header_size() >= used) ? longint'(eff_header_size() - used) : 0;
		begin_skip(33'(rest + longint'(pack_size)));
	endfunction

	function automatic void walk_archive_byte(logic [7:0] b, logic last);
		name_word_t w;
		logic       first;
		logic       fin;
		case (walk_phase)
			PH_BASE: begin
				if (hdr_idx == 2)
					blk_kind = b;
				else if (hdr_idx == 5)
					blk_hsize[7:0] = b;
				else if (hdr_idx == 6)
					blk_hsize[15:8] = b;
				hdr_idx++;
				if (hdr_idx >= BaseLen) begin
					hdr_idx = '0;
					if (blk_kind == KindFile) begin
						pack_size = '0;
						name_len = '0;
						name_left = '0;
						walk_phase = PH_FILE;
					end else begin
						begin_skip(33'(eff_header_size() - BaseLen));
					end
				end
			end
			PH_FILE: begin
				if (hdr_idx < 4)
					pack_size[8 * hdr_idx +: 8] = b;
				else if (hdr_idx == 19)
					name_len[7:0] = b;
				else if (hdr_idx == 20)
					name_len[15:8] = b;
				hdr_idx++;
				if (hdr_idx >= FileHdrLen) begin
					hdr_idx = '0;
					name_left = name_len;
					if (name_len != '0)
						walk_phase = PH_NAME;
					else
						close_file_header();
				end
			end
			PH_NAME: begin
				first = (name_left == name_len);
				name_left = name_left - 16'd1;
				fin = (name_left == '0);
				w.name_byte = b;
				w.name_first = first;
				w.name_last = fin | last;
				w.name_truncated = last & ~fin;
				w.packed_length = pack_size;
				name_words_due.push_back(w);
				if (fin)
					close_file_header();
			end
			PH_SKIP: begin
				skip_left = skip_left - 33'd1;
				if (skip_left == '0) begin
					hdr_idx = '0;
					walk_phase = PH_BASE;
				end
			end
			default: begin
				hdr_idx++;
				if (hdr_idx >= BaseLen) begin
					hdr_idx = '0;
					walk_phase = PH_BASE;
				end
			end
		endcase
		if (last)
			walk_reset();
	endfunction

	// Archive construction
	function automatic void put_le(longint v, int n);
		for (int i = 0; i < n; i++)
			archive_draft.push_back(8'(v >> (8 * i)));
	endfunction

	function automatic void put_random(longint n);
		for (longint i = 0; i < n; i++)
			archive_draft.push_back(8'($urandom));
	endfunction

	function automatic void put_base_header(logic [7:0] kind, int hs);
		put_random(2);
		archive_draft.push_back(kind);
		put_random(2);
		put_le(hs, 2);
	endfunction

	// Push the skipped bytes; cut a long skip short and report the archive as ended.
	function automatic bit put_skip(longint total);
		longint keep;
		keep = (total > 40) ? longint'($urandom_range(0, 5)) : total;
		put_random(keep);
		return keep < total;
	endfunction

	function automatic bit put_file_block(int hs, int unsigned ps, int ns, int name_keep,
		int name_fill);
		int keep;
		int hs_eff;
		int used;
		put_base_header(KindFile, hs);
		put_le(ps, 4);
		put_random(15);
		put_le(ns, 2);
		put_random(4);
		keep = (name_keep < ns) ? name_keep : ns;
		for (int i = 0; i < keep; i++)
			archive_draft.push_back((name_fill < 0) ? 8'($urandom) : 8'(name_fill));
		planned_names += keep;
		if (keep < ns)
			return 1'b1;
		hs_eff = (hs < BaseLen) ? BaseLen : hs;
		used = BaseLen + FileHdrLen + ns;
		return put_skip(longint'((hs_eff >= used) ? hs_eff - used : 0) + longint'(ps));
	endfunction

	function automatic bit put_other_block(logic [7:0] kind, int hs);
		put_base_header(kind, hs);
		return put_skip(longint'(((hs < BaseLen) ? BaseLen : hs) - BaseLen));
	endfunction

	function automatic void flush_draft(bit drain);
		archive_item_t it;
		for (int i = 0; i < archive_draft.size(); i++) begin
			it.data = archive_draft[i];
			it.last = (i == archive_draft.size() - 1);
			it.drain = drain && (i == 0);
			archive_pending.push_back(it);
		end
		archive_draft.delete();
	endfunction

	function automatic void random_archive();
		int   nblk;
		bit   ended;
		int   ns;
		int   hs;
		int   sel;
		int   cut;
		int   unsigned ps;
		logic [7:0] kind;
		ended = 1'b0;
		put_random(7);
		nblk = $urandom_range(1, 4);
		for (int i = 0; i < nblk && !ended; i++) begin
			if ($urandom_range(0, 2) != 0) begin
				ns = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 65535) : $urandom_range(0, 9);
				sel = $urandom_range(0, 9);
				if (sel == 0)
					hs = $urandom_range(0, 6);
				else if (sel == 1)
					hs = $urandom_range(7, 32 + ns);
				else if (sel == 2)
					hs = $urandom_range(0, 65535);
				else
					hs = 32 + ns + $urandom_range(0, 4);
				if (hs > 65535)
					hs = 65535;
				ps = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
				if (ns > 12)
					ended = put_file_block(hs, ps, ns, $urandom_range(1, 6), -1);
				else if ($urandom_range(0, 15) == 0)
					ended = put_file_block(hs, ps, ns, $urandom_range(0, ns), -1);
				else
					ended = put_file_block(hs, ps, ns, ns, -1);
			end else begin
				kind = 8'($urandom);
				if (kind == KindFile)
					kind = 8'h7a;
				sel = $urandom_range(0, 9);
				if (sel == 0)
					hs = $urandom_range(0, 6);
				else if (sel == 1)
					hs = $urandom_range(0, 65535);
				else
					hs = $urandom_range(7, 20);
				ended = put_other_block(kind, hs);
			end
		end
		// End the archive at an arbitrary point now and then.
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, archive_draft.size());
			while (archive_draft.size() > cut)
				void'(archive_draft.pop_back());
		end
		flush_draft($urandom_range(0, 24) == 0);
	endfunction

	function automatic void noise_burst();
		archive_item_t it;
		int n;
		n = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			it.data = 8'($urandom);
			it.last = (i == n - 1) || ($urandom_range(0, 7) == 0);
			it.drain = 1'b0;
			archive_pending.push_back(it);
		end
	endfunction

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Archive driver
	int send_gap;
	bit send_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			archive_if.valid <= 1'b0;
			archive_if.archive_byte <= '0;
			archive_if.stream_last <= 1'b0;
			send_gap <= 0;
			send_calm <= 1'b0;
		end else begin
			if (archive_if.valid && archive_if.ready)
				walk_archive_byte(archive_if.archive_byte, archive_if.stream_last);
			if (!archive_if.valid || archive_if.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					archive_if.valid <= 1'b0;
				end else if (archive_pending.size() != 0 &&
					(!archive_pending[0].drain || name_words_due.size() == 0)) begin
					archive_if.valid <= 1'b1;
					archive_if.archive_byte <= archive_pending[0].data;
					archive_if.stream_last <= archive_pending[0].last;
					void'(archive_pending.pop_front());
					if ($urandom_range(0, 63) == 0)
						send_calm <= !send_calm;
					send_gap <= send_calm ? 0 : $urandom_range(0, 14);
				end else begin
					archive_if.valid <= 1'b0;
				end
			end
		end
	end

	// Name word monitor
	int  recv_stall;
	bit  recv_calm;

	always @(posedge clk or negedge arst_n) begin : name_check
		name_word_t due;
		int         s;
		if (!arst_n) begin
			names_if.ready <= 1'b0;
			recv_stall <= 0;
			recv_calm <= 1'b0;
		end else begin
			s = recv_stall;
			if (names_if.valid && names_if.ready) begin
				if (name_words_due.size() == 0) begin
					$error("name word %h arrived with nothing due", names_if.name_byte);
					fail_count++;
				end else begin
					due = name_words_due.pop_front();
					if (names_if.name_byte !== due.name_byte) begin
						$error("name_byte: expected %h, got %h", due.name_byte, names_if.name_byte);
						fail_count++;
					end
					if (names_if.name_first !== due.name_first) begin
						$error("name_first: expected %b, got %b", due.name_first,
							names_if.name_first);
						fail_count++;
					end
					if (names_if.name_last !== due.name_last) begin
						$error("name_last: expected %b, got %b", due.name_last, names_if.name_last);
						fail_count++;
					end
					if (names_if.name_truncated !== due.name_truncated) begin
						$error("name_truncated: expected %b, got %b", due.name_truncated,
							names_if.name_truncated);
						fail_count++;
					end
					if (names_if.packed_length !== due.packed_length) begin
						$error("packed_length: expected %h, got %h", due.packed_length,
							names_if.packed_length);
						fail_count++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					recv_calm <= !recv_calm;
				s = recv_calm ? 0 : $urandom_range(0, 14);
			end else if (s > 0) begin
				s--;
			end
			recv_stall <= s;
			names_if.ready <= (s == 0);
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		int base_count;
		int drain_wait;
		bit ended;
		fail_count = 0;
		planned_names = 0;
		walk_reset();

		// Plain name, zero-length skip, empty name, short other block.
		put_random(7);
		ended = put_file_block(35, 2, 3, 3, 8'hff);
		ended = put_other_block(8'h73, 7);
		ended = put_file_block(32, 1, 0, 0, -1);
		ended = put_other_block(8'h7b, 9);
		flush_draft(1'b0);
		// Size fields below seven, short file header, full packed size ending mid-skip.
		put_random(7);
		ended = put_other_block(8'h00, 3);
		ended = put_file_block(5, 32'hffff_ffff, 2, 2, -1);
		flush_draft(1'b1);
		// Longest name, cut off by the end of the archive.
		put_random(7);
		ended = put_file_block(65535, 32'h8000_0001, 65535, 3, 8'h00);
		flush_draft(1'b0);
		// Archive ending inside the signature.
		put_random(3);
		flush_draft(1'b0);
		// Archive ending exactly on the last name byte.
		put_random(7);
		ended = put_file_block(33, 0, 1, 1, -1);
		flush_draft(1'b0);
		// Largest other block, ended mid-skip.
		put_random(7);
		ended = put_other_block(8'hff, 65535);
		flush_draft(1'b0);

		base_count = archive_pending.size();
		planned_names = 0;
		while (archive_pending.size() - base_count < 1850 || planned_names < 60) begin
			if ($urandom_range(0, 7) == 0)
				noise_burst();
			else
				random_archive();
		end

		@(posedge arst_n);
		while (archive_pending.size() != 0 || archive_if.valid)
			@(posedge clk);
		drain_wait = 0;
		while (name_words_due.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		if (name_words_due.size() != 0) begin
			$error("%0d name words never arrived", name_words_due.size());
			fail_count++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/rar4hw_pkg.sv
src/rar4hw_ifs.sv
src/rar4hw_walker.sv
src/rar4_header_walk_name_extract.sv
sim/tb_rar4_header_walk_name_extract.sv
